### design/swa_pkg.sv
// Shared types and constants for the sensor window averager.
`timescale 1ns / 1ps
package swa_pkg;

    // Tick counter
    localparam int COUNT_WIDTH = 11;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Field widths
    localparam int TEMP_INT_W  = 8;
    localparam int TEMP_FRAC_W = 7;
    localparam int HUMID_INT_W = 7;
    localparam int HUMID_FRAC_W = 7;
    localparam int LUX_W       = 16;
    localparam int SEL_W       = 2;
    localparam int LEN_W       = 11;
    localparam int IDX_W       = 3;
    localparam int TDATA_W     = 48;

    // Running sums
    localparam int TEMP_INT_SUM_W   = 19;
    localparam int TEMP_FRAC_SUM_W  = 18;
    localparam int HUMID_INT_SUM_W  = 18;
    localparam int HUMID_FRAC_SUM_W = 18;
    localparam int LUX_SUM_W        = 28;

    // Divider: dividend width covers the widest sum and the combined values
    localparam int DIV_W  = 28;
    localparam int STEP_W = $clog2(DIV_W);

    // Limit compare is done at a width that holds both count and length
    localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

    // Hundredths scaling and caps
    localparam int SCALE       = 100;
    localparam int T_W         = 15;
    localparam int H_W         = 14;
    localparam logic [T_W-1:0] TEMP_CAP  = 15'd25599;
    localparam logic [H_W-1:0] HUMID_CAP = 14'd10099;

    // x / 100 == (x * 5243) >> 19 for x below 43690
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
    localparam int RECIP_SHIFT = 19;

    // Reset values of the window lengths
    localparam logic [LEN_W-1:0] LEN0_RST = 11'd15;
    localparam logic [LEN_W-1:0] LEN1_RST = 11'd30;
    localparam logic [LEN_W-1:0] LEN2_RST = 11'd60;
    localparam logic [LEN_W-1:0] LEN3_RST = 11'd1440;

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_SELECT = 3'd0,
        REG_WINDOW_LEN_0  = 3'd1,
        REG_WINDOW_LEN_1  = 3'd2,
        REG_WINDOW_LEN_2  = 3'd3,
        REG_WINDOW_LEN_3  = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_CAP,
        S_SCALE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accum;  // add the accepted word into the sums
        logic load;   // start the dividers, clear the window
        logic step;   // one divider iteration
        logic cap;    // take quotients, saturate
        logic scale;  // reciprocal multiply for the whole parts
        logic emit;   // fill the output register
    } t_dp_cmd;

endpackage

### design/swa_div.sv
// Restoring divider, one quotient bit per cycle while i_step is high.
`timescale 1ns / 1ps
module swa_div (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic                            i_step,
    input  logic [swa_pkg::DIV_W-1:0]       i_dividend,
    input  logic [swa_pkg::COUNT_WIDTH-1:0] i_divisor,
    output logic [swa_pkg::DIV_W-1:0]       o_quotient
);
    import swa_pkg::*;

    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_dvs;
    logic [DIV_W-1:0]       r_quo;
    logic [COUNT_WIDTH:0]   shifted;
    logic [COUNT_WIDTH:0]   trial;
    logic                   take;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        take    = (shifted >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (i_step) begin
            r_rem <= take ? trial[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[DIV_W-2:0], take};
        end
    end

    assign o_quotient = r_quo;

endmodule

### design/swa_ctrl.sv
// Sequencer for accumulate, divide, split and output handoff.
`timescale 1ns / 1ps
module swa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  logic             i_fire,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output swa_pkg::t_dp_cmd o_cmd
);
    import swa_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [STEP_W-1:0]  r_step_cnt;
    logic [STEP_W-1:0]  n_step_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step_cnt  <= n_step_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step_cnt  = r_step_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.accum = i_in_valid;
                if (i_in_valid && i_fire) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step_cnt = STEP_W'(DIV_W - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_step_cnt = r_step_cnt - 1'b1;
                if (r_step_cnt == '0) begin
                    n_state = S_CAP;
                end
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register can take the word
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/swa_datapath.sv
// Window registers, running sums, three dividers and the output register.
`timescale 1ns / 1ps
module swa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swa_pkg::t_dp_cmd              i_cmd,
    input  logic                          i_cfg_write,
    input  logic [swa_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [swa_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic [swa_pkg::TDATA_W-1:0]   i_in_data,
    output logic                          o_fire,
    output logic [swa_pkg::TDATA_W-1:0]   o_out_data
);
    import swa_pkg::*;

    // configuration
    logic [SEL_W-1:0] r_sel;
    logic [LEN_W-1:0] r_len [4];

    // window state
    logic [COUNT_WIDTH-1:0]      r_count;
    logic [COUNT_WIDTH-1:0]      n_count;
    logic [TEMP_INT_SUM_W-1:0]   r_ti_sum;
    logic [TEMP_FRAC_SUM_W-1:0]  r_tf_sum;
    logic [HUMID_INT_SUM_W-1:0]  r_hi_sum;
    logic [HUMID_FRAC_SUM_W-1:0] r_hf_sum;
    logic [LUX_SUM_W-1:0]        r_lux_sum;

    // input fields
    logic [TEMP_INT_W-1:0]   in_ti;
    logic [TEMP_FRAC_W-1:0]  in_tf;
    logic [HUMID_INT_W-1:0]  in_hi;
    logic [HUMID_FRAC_W-1:0] in_hf;
    logic [LUX_W-1:0]        in_lux;

    logic [LEN_W-1:0] limit_raw;
    logic [CMP_W-1:0] limit;

    logic [DIV_W-1:0] t_comb;
    logic [DIV_W-1:0] h_comb;
    logic [DIV_W-1:0] t_quo;
    logic [DIV_W-1:0] h_quo;
    logic [DIV_W-1:0] l_quo;

    logic [T_W-1:0]   r_t;
    logic [H_W-1:0]   r_h;
    logic [LUX_W-1:0] r_lux_q;
    logic [TEMP_INT_W-1:0]  r_t_int;
    logic [HUMID_INT_W-1:0] r_h_int;

    logic [T_W+RECIP_W-1:0] t_prod;
    logic [H_W+RECIP_W-1:0] h_prod;
    logic [T_W-1:0]         t_rem;
    logic [H_W-1:0]         h_rem;

    logic [TEMP_INT_W-1:0]   r_o_ti;
    logic [TEMP_FRAC_W-1:0]  r_o_tf;
    logic [HUMID_INT_W-1:0]  r_o_hi;
    logic [HUMID_FRAC_W-1:0] r_o_hf;
    logic [LUX_W-1:0]        r_o_lux;

    assign in_ti  = i_in_data[7:0];
    assign in_tf  = i_in_data[14:8];
    assign in_hi  = i_in_data[21:15];
    assign in_hf  = i_in_data[28:22];
    assign in_lux = i_in_data[44:29];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel    <= '0;
            r_len[0] <= LEN0_RST;
            r_len[1] <= LEN1_RST;
            r_len[2] <= LEN2_RST;
            r_len[3] <= LEN3_RST;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                REG_WINDOW_SELECT: r_sel    <= i_cfg_data[SEL_W-1:0];
                REG_WINDOW_LEN_0:  r_len[0] <= i_cfg_data;
                REG_WINDOW_LEN_1:  r_len[1] <= i_cfg_data;
                REG_WINDOW_LEN_2:  r_len[2] <= i_cfg_data;
                REG_WINDOW_LEN_3:  r_len[3] <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // zero length acts as one; a length past the counter saturates
    always_comb begin
        limit_raw = r_len[r_sel];
        n_count   = (r_count < CNT_MAX) ? r_count + 1'b1 : r_count;
        if (limit_raw == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(limit_raw) > CMP_W'(CNT_MAX)) begin
            limit = CMP_W'(CNT_MAX);
        end else begin
            limit = CMP_W'(limit_raw);
        end
        o_fire = (CMP_W'(n_count) >= limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ti_sum  <= '0;
            r_tf_sum  <= '0;
            r_hi_sum  <= '0;
            r_hf_sum  <= '0;
            r_lux_sum <= '0;
        end else if (i_cmd.load) begin
            r_count   <= '0;
            r_ti_sum  <= '0;
            r_tf_sum  <= '0;
            r_hi_sum  <= '0;
            r_hf_sum  <= '0;
            r_lux_sum <= '0;
        end else if (i_cmd.accum) begin
            r_count   <= n_count;
            r_ti_sum  <= r_ti_sum + TEMP_INT_SUM_W'(in_ti);
            r_tf_sum  <= r_tf_sum + TEMP_FRAC_SUM_W'(in_tf);
            r_hi_sum  <= r_hi_sum + HUMID_INT_SUM_W'(in_hi);
            r_hf_sum  <= r_hf_sum + HUMID_FRAC_SUM_W'(in_hf);
            r_lux_sum <= r_lux_sum + LUX_SUM_W'(in_lux);
        end
    end

    // whole * 100 + hundredths
    assign t_comb = DIV_W'(r_ti_sum) * DIV_W'(SCALE) + DIV_W'(r_tf_sum);
    assign h_comb = DIV_W'(r_hi_sum) * DIV_W'(SCALE) + DIV_W'(r_hf_sum);

    swa_div u_div_temp (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load),
        .i_step     (i_cmd.step),
        .i_dividend (t_comb),
        .i_divisor  (r_count),
        .o_quotient (t_quo)
    );

    swa_div u_div_humid (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load),
        .i_step     (i_cmd.step),
        .i_dividend (h_comb),
        .i_divisor  (r_count),
        .o_quotient (h_quo)
    );

    swa_div u_div_lux (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load),
        .i_step     (i_cmd.step),
        .i_dividend (DIV_W'(r_lux_sum)),
        .i_divisor  (r_count),
        .o_quotient (l_quo)
    );

    assign t_prod = (T_W+RECIP_W)'(r_t) * (T_W+RECIP_W)'(RECIP);
    assign h_prod = (H_W+RECIP_W)'(r_h) * (H_W+RECIP_W)'(RECIP);
    assign t_rem  = r_t - T_W'(r_t_int) * T_W'(SCALE);
    assign h_rem  = r_h - H_W'(r_h_int) * H_W'(SCALE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_t     <= (t_quo > DIV_W'(TEMP_CAP)) ? TEMP_CAP : t_quo[T_W-1:0];
            r_h     <= (h_quo > DIV_W'(HUMID_CAP)) ? HUMID_CAP : h_quo[H_W-1:0];
            r_lux_q <= l_quo[LUX_W-1:0];
        end
        if (i_cmd.scale) begin
            r_t_int <= t_prod[RECIP_SHIFT +: TEMP_INT_W];
            r_h_int <= h_prod[RECIP_SHIFT +: HUMID_INT_W];
        end
        if (i_cmd.emit) begin
            r_o_ti  <= r_t_int;
            r_o_tf  <= t_rem[TEMP_FRAC_W-1:0];
            r_o_hi  <= r_h_int;
            r_o_hf  <= h_rem[HUMID_FRAC_W-1:0];
            r_o_lux <= r_lux_q;
        end
    end

    assign o_out_data = {3'b000, r_o_lux, r_o_hf, r_o_hi, r_o_tf, r_o_ti};

endmodule

### design/sensor_window_averager_core.sv
// Top level of the sensor window averager: block average of three sensor channels.
//
//  channel  | direction | handshake                       | payload
//  ---------+-----------+---------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready   | one tick: temp, humidity, lux
//  m_axis   | out       | m_axis_tvalid / m_axis_tready   | window averages
//  cfg      | in        | i_cfg_valid / o_cfg_ready       | register index + 11-bit value
//
// A tick that does not close a window is added to the sums; the block stays ready. A tick
// that closes it is added, then the sequencer runs S_LOAD, S_DIV (bit-serial dividers, one
// quotient bit a cycle, dividend width 28), S_CAP and S_SCALE (saturation, split into
// whole and hundredths) and S_EMIT (fill the output register). A finished word waits in
// the output register while new ticks are taken; s_axis_tready is low from S_LOAD through
// S_EMIT, and S_EMIT holds when the next window closes before that word is taken. Reset is
// synchronous, active low, and restores the window registers to select 0 with lengths 15, 30, 60, 1440.
`timescale 1ns / 1ps
module sensor_window_averager_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // temp_int_in[7:0], temp_frac_in[14:8], humid_int_in[21:15],
    // humid_frac_in[28:22], lux_in[44:29], zero fill[47:45]
    input  logic [swa_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // temp_int_mean[7:0], temp_frac_mean[14:8], humid_int_mean[21:15],
    // humid_frac_mean[28:22], lux_mean[44:29], zero fill[47:45]
    output logic [swa_pkg::TDATA_W-1:0]   m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swa_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [swa_pkg::LEN_W-1:0]     i_cfg_data
);
    import swa_pkg::*;

    t_dp_cmd cmd;
    logic    fire;

    assign o_cfg_ready = 1'b1;

    swa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_fire      (fire),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    swa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_fire      (fire),
        .o_out_data  (m_axis_tdata)
    );

endmodule
